// ----- rtl/core/bscrc_pkg.sv -----
// Shared types and constants for the bit-serial CRC generator.
package bscrc_pkg;

    localparam int CRC_OUT_W     = 32;
    localparam int CRC_BIT_IDX_W = $clog2(CRC_OUT_W);
    localparam int WIDTH_W       = 6;
    localparam int POLY_W        = 33;
    localparam int CFG_DATA_W    = 33;
    localparam int CFG_INDEX_W   = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [WIDTH_W-1:0]   MIN_CRC_WIDTH  = 6'd4;
    localparam logic [WIDTH_W-1:0]   CRC_WIDTH_RST  = 6'd24;
    localparam logic [POLY_W-1:0]    POLY_RST       = 33'd25578747;
    localparam logic [CRC_OUT_W-1:0] INIT_RST       = '0;
    localparam logic                 APPEND_RST     = 1'b0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CRC_WIDTH     = 2'd0,
        CFG_POLYNOMIAL    = 2'd1,
        CFG_INIT_VALUE    = 2'd2,
        CFG_APPEND_ENABLE = 2'd3
    } cfg_index_t;

    typedef enum logic {
        KIND_CRC = 1'b0,
        KIND_BIT = 1'b1
    } result_kind_t;

    // one finished message handed from the front end to the emitter
    typedef struct packed {
        logic [CRC_OUT_W-1:0] crc;
        logic [WIDTH_W-1:0]   width;
        logic                 append;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/core/bscrc_front.sv -----
// Front end: takes message bits and runs the CRC shift register.
module bscrc_front #(
    parameter int MAX_CRC_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_data_bit,
    input  logic                                 s_end_of_message,
    input  logic [bscrc_pkg::WIDTH_W-1:0]        eff_width,
    input  logic [bscrc_pkg::POLY_W-1:0]         polynomial,
    input  logic [bscrc_pkg::CRC_OUT_W-1:0]      init_value,
    input  logic                                 append_enable,
    input  bscrc_pkg::queue_status_t             q_stat,
    output logic                                 push,
    output bscrc_pkg::job_t                      push_job
);

    localparam int IDX_W = $clog2(MAX_CRC_WIDTH);

    logic [MAX_CRC_WIDTH-1:0] crc_reg, crc_next;
    logic                     in_msg_reg, in_msg_next;
    logic [MAX_CRC_WIDTH-1:0] mask;
    logic [MAX_CRC_WIDTH-1:0] cur;
    logic [IDX_W-1:0]         top_idx;
    logic                     fb;
    logic                     accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
            mask[i] = (bscrc_pkg::WIDTH_W'(i) < eff_width);
        end
    end

    assign top_idx = IDX_W'(eff_width - bscrc_pkg::WIDTH_W'(1));

    always_comb begin
        // first bit of a message starts from the init value
        cur = (in_msg_reg ? crc_reg : init_value[MAX_CRC_WIDTH-1:0]) & mask;
        fb  = cur[top_idx] ^ s_data_bit;
        crc_next = (cur << 1) & mask;
        if (fb) begin
            crc_next = crc_next ^ (polynomial[MAX_CRC_WIDTH-1:0] & mask);
        end
        in_msg_next = !s_end_of_message;
    end

    assign push            = accept && s_end_of_message;
    assign push_job.crc    = bscrc_pkg::CRC_OUT_W'(crc_next);
    assign push_job.width  = eff_width;
    assign push_job.append = append_enable;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= '0;
            in_msg_reg <= 1'b0;
        end else if (accept) begin
            crc_reg    <= crc_next;
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

// ----- rtl/core/bscrc_queue.sv -----
// Small job queue between the CRC front end and the result emitter.
module bscrc_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  bscrc_pkg::job_t           push_job,
    input  logic                      pop,
    output bscrc_pkg::job_t           head,
    output bscrc_pkg::queue_status_t  q_stat
);

    localparam int DEPTH = bscrc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bscrc_pkg::job_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/bscrc_back.sv -----
// Result emitter: sends the CRC word and, if enabled, the CRC bits MSB first.
module bscrc_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bscrc_pkg::job_t                      head,
    input  bscrc_pkg::queue_status_t             q_stat,
    output logic                                 pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_result_kind,
    output logic [bscrc_pkg::CRC_OUT_W-1:0]      m_crc_value,
    output logic                                 m_appended_bit,
    output logic                                 m_last_result
);

    typedef enum logic [1:0] {
        PH_CRC  = 2'b01,
        PH_BITS = 2'b10
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [bscrc_pkg::CRC_BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic                                  m_valid_reg, m_valid_next;
    logic                                  kind_reg, kind_next;
    logic [bscrc_pkg::CRC_OUT_W-1:0]       crc_value_reg, crc_value_next;
    logic                                  app_bit_reg, app_bit_next;
    logic                                  last_reg, last_next;
    logic                                  advance;

    // output register is free or being drained this cycle
    assign advance = !m_valid_reg || m_ready;

    always_comb begin
        phase_next     = phase_reg;
        bit_idx_next   = bit_idx_reg;
        m_valid_next   = m_valid_reg;
        kind_next      = kind_reg;
        crc_value_next = crc_value_reg;
        app_bit_next   = app_bit_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (advance) begin
            m_valid_next = 1'b0;
            if (!q_stat.empty) begin
                m_valid_next = 1'b1;
                case (phase_reg)
                    PH_CRC: begin
                        kind_next      = bscrc_pkg::KIND_CRC;
                        crc_value_next = head.crc;
                        app_bit_next   = 1'b0;
                        last_next      = !head.append;
                        if (head.append) begin
                            phase_next   = PH_BITS;
                            bit_idx_next = bscrc_pkg::CRC_BIT_IDX_W'(
                                head.width - bscrc_pkg::WIDTH_W'(1));
                        end else begin
                            pop = 1'b1;
                        end
                    end
                    PH_BITS: begin
                        kind_next      = bscrc_pkg::KIND_BIT;
                        crc_value_next = '0;
                        app_bit_next   = head.crc[bit_idx_reg];
                        last_next      = (bit_idx_reg == '0);
                        if (bit_idx_reg == '0) begin
                            pop        = 1'b1;
                            phase_next = PH_CRC;
                        end else begin
                            bit_idx_next = bit_idx_reg - bscrc_pkg::CRC_BIT_IDX_W'(1);
                        end
                    end
                    default: begin
                        m_valid_next = 1'b0;
                        phase_next   = PH_CRC;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_CRC;
            bit_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            bit_idx_reg <= bit_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        crc_value_reg <= crc_value_next;
        app_bit_reg   <= app_bit_next;
        last_reg      <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_crc_value    = crc_value_reg;
    assign m_appended_bit = app_bit_reg;
    assign m_last_result  = last_reg;

endmodule

// ----- rtl/core/bit_serial_crc_generator.sv -----
// Top level of the bit-serial MSB-first CRC generator.
//
// Message bits enter on the s_ channel, one word per bit, most significant
// first; s_end_of_message marks the last bit. The next bit after an end mark
// starts a new message from init_value. Only end-marked bits produce output.
// For each message the m_ channel delivers one CRC word (m_result_kind = 0),
// then, with append_enable set, L appended-bit words (m_result_kind = 1),
// MSB first. m_last_result flags the final word of each message.
// Input rate: one bit per cycle while s_ready is high; each bit is a single
// LFSR shift in the front end. An end-marked bit's CRC reaches m_ through the
// job queue and the emitter's output register. The emitter sends one word per
// cycle while m_ready is high (L + 1 words per appending message); a two-entry
// job queue lets the front end keep taking bits meanwhile, and s_ready drops
// only while that queue is full. An m_ stall holds the current word and backs
// up into the queue. Reset (aresetn low, synchronous) clears the CRC state,
// queue and output valid and loads the configuration defaults. Configuration
// writes through cfg_we / cfg_index / cfg_wdata take effect on the next bit.
module bit_serial_crc_generator #(
    parameter int MAX_CRC_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [bscrc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [bscrc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_data_bit,
    input  logic                                    s_end_of_message,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_result_kind,
    output logic [bscrc_pkg::CRC_OUT_W-1:0]         m_crc_value,
    output logic                                    m_appended_bit,
    output logic                                    m_last_result
);

    localparam logic [bscrc_pkg::WIDTH_W-1:0] MAX_W = bscrc_pkg::WIDTH_W'(MAX_CRC_WIDTH);

    logic [bscrc_pkg::WIDTH_W-1:0]   crc_width_reg, crc_width_next;
    logic [bscrc_pkg::POLY_W-1:0]    poly_reg, poly_next;
    logic [bscrc_pkg::CRC_OUT_W-1:0] init_reg, init_next;
    logic                            append_reg, append_next;
    logic [bscrc_pkg::WIDTH_W-1:0]   w_sat, eff_width;

    bscrc_pkg::queue_status_t q_stat;
    bscrc_pkg::job_t          push_job, head;
    logic                     push, pop;

    always_comb begin
        crc_width_next = crc_width_reg;
        poly_next      = poly_reg;
        init_next      = init_reg;
        append_next    = append_reg;
        if (cfg_we) begin
            case (cfg_index)
                bscrc_pkg::CFG_CRC_WIDTH:
                    crc_width_next = cfg_wdata[bscrc_pkg::WIDTH_W-1:0];
                bscrc_pkg::CFG_POLYNOMIAL:
                    poly_next = cfg_wdata[bscrc_pkg::POLY_W-1:0];
                bscrc_pkg::CFG_INIT_VALUE:
                    init_next = cfg_wdata[bscrc_pkg::CRC_OUT_W-1:0];
                bscrc_pkg::CFG_APPEND_ENABLE:
                    append_next = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_width_reg <= bscrc_pkg::CRC_WIDTH_RST;
            poly_reg      <= bscrc_pkg::POLY_RST;
            init_reg      <= bscrc_pkg::INIT_RST;
            append_reg    <= bscrc_pkg::APPEND_RST;
        end else begin
            crc_width_reg <= crc_width_next;
            poly_reg      <= poly_next;
            init_reg      <= init_next;
            append_reg    <= append_next;
        end
    end

    // clamp to the supported range, then drop to an even width
    always_comb begin
        w_sat = crc_width_reg;
        if (w_sat < bscrc_pkg::MIN_CRC_WIDTH) begin
            w_sat = bscrc_pkg::MIN_CRC_WIDTH;
        end
        if (w_sat > MAX_W) begin
            w_sat = MAX_W;
        end
        eff_width = {w_sat[bscrc_pkg::WIDTH_W-1:1], 1'b0};
    end

    bscrc_front #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_bit       (s_data_bit),
        .s_end_of_message (s_end_of_message),
        .eff_width        (eff_width),
        .polynomial       (poly_reg),
        .init_value       (init_reg),
        .append_enable    (append_reg),
        .q_stat           (q_stat),
        .push             (push),
        .push_job         (push_job)
    );

    bscrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    bscrc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .q_stat         (q_stat),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_crc_value    (m_crc_value),
        .m_appended_bit (m_appended_bit),
        .m_last_result  (m_last_result)
    );

    // a message's words go out without gaps once the first one is taken
    a_no_gap_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_result |=> m_valid)
        else $error("gap inside a result run");

    // a full queue means the emitter already holds a word
    a_full_implies_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> m_valid)
        else $error("queue full while output idle");

    // unused fields are zero for each result kind
    a_kind_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind == bscrc_pkg::KIND_CRC) ? !m_appended_bit
                                                           : (m_crc_value == '0))
        else $error("stray field value in result word");

    // the queue is never pushed while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("job queue overflow");

endmodule

// ----- bench/tb_bit_serial_crc_generator.sv -----
// Self-checking testbench for the bit-serial CRC generator: random handshakes, CRC prediction.
module tb_bit_serial_crc_generator;

    localparam int MAX_W         = 32;
    localparam int RANDOM_ITEMS  = 140;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam logic [3:0] ALL_REGS = 4'hF;

    typedef struct {
        bscrc_pkg::result_kind_t         kind;
        logic [bscrc_pkg::CRC_OUT_W-1:0] crc_value;
        logic                            appended_bit;
        logic                            last_result;
    } crc_word_t;

    // Tracks the CRC state and configuration, queues the words each bit produces.
    class crc_tracker;
        logic [bscrc_pkg::WIDTH_W-1:0]   width_reg;
        logic [bscrc_pkg::POLY_W-1:0]    poly_reg;
        logic [bscrc_pkg::CRC_OUT_W-1:0] init_reg;
        logic                            append_reg;
        logic [bscrc_pkg::CRC_OUT_W-1:0] crc_reg;
        bit                              open_msg;
        crc_word_t                       expected_words[$];
        int                              errors;

        function new();
            width_reg  = bscrc_pkg::CRC_WIDTH_RST;
            poly_reg   = bscrc_pkg::POLY_RST;
            init_reg   = bscrc_pkg::INIT_RST;
            append_reg = bscrc_pkg::APPEND_RST;
            crc_reg    = '0;
            open_msg   = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(bscrc_pkg::cfg_index_t idx,
                                logic [bscrc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                bscrc_pkg::CFG_CRC_WIDTH:     width_reg  = val[bscrc_pkg::WIDTH_W-1:0];
                bscrc_pkg::CFG_POLYNOMIAL:    poly_reg   = val[bscrc_pkg::POLY_W-1:0];
                bscrc_pkg::CFG_INIT_VALUE:    init_reg   = val[bscrc_pkg::CRC_OUT_W-1:0];
                bscrc_pkg::CFG_APPEND_ENABLE: append_reg = val[0];
                default: ;
            endcase
        endfunction

        // saturate to the legal range, then drop the low bit
        function int unsigned live_width();
            int unsigned w;
            w = width_reg;
            if (w < bscrc_pkg::MIN_CRC_WIDTH) w = bscrc_pkg::MIN_CRC_WIDTH;
            if (w > MAX_W) w = MAX_W;
            w = w & ~32'd1;
            return w;
        endfunction

        function void take_bit(logic d, logic e);
            int unsigned                     w;
            int unsigned                     i;
            logic [bscrc_pkg::CRC_OUT_W-1:0] mask;
            logic                            fb;
            crc_word_t                       wd;
            w = live_width();
            mask = 32'hFFFF_FFFF >> (bscrc_pkg::CRC_OUT_W - w);
            if (!open_msg) begin
                crc_reg  = init_reg & mask;
                open_msg = 1'b1;
            end
            crc_reg = crc_reg & mask;
            fb = crc_reg[w-1] ^ d;
            crc_reg = (crc_reg << 1) & mask;
            if (fb) crc_reg = crc_reg ^ (poly_reg[bscrc_pkg::CRC_OUT_W-1:0] & mask);
            if (!e) return;
            open_msg = 1'b0;
            wd.kind         = bscrc_pkg::KIND_CRC;
            wd.crc_value    = crc_reg;
            wd.appended_bit = 1'b0;
            wd.last_result  = !append_reg;
            expected_words.push_back(wd);
            if (append_reg) begin
                for (i = 0; i < w; i++) begin
                    wd.kind         = bscrc_pkg::KIND_BIT;
                    wd.crc_value    = '0;
                    wd.appended_bit = crc_reg[w-1-i];
                    wd.last_result  = (i == w - 1);
                    expected_words.push_back(wd);
                end
            end
        endfunction

        function void field_diff(string field, logic [bscrc_pkg::CRC_OUT_W-1:0] exp_v,
                                 logic [bscrc_pkg::CRC_OUT_W-1:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(logic kind, logic [bscrc_pkg::CRC_OUT_W-1:0] crc,
                                 logic abit, logic last);
            crc_word_t wd;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual kind %b crc %h bit %b last %b",
                         $time, kind, crc, abit, last);
                errors++;
                return;
            end
            wd = expected_words.pop_front();
            field_diff("result_kind", 32'(wd.kind), 32'(kind));
            field_diff("crc_value", wd.crc_value, crc);
            field_diff("appended_bit", 32'(wd.appended_bit), 32'(abit));
            field_diff("last_result", 32'(wd.last_result), 32'(last));
        endfunction
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [bscrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bscrc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic                              s_data_bit = 1'b0;
    logic                              s_end_of_message = 1'b0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_result_kind;
    logic [bscrc_pkg::CRC_OUT_W-1:0]   m_crc_value;
    logic                              m_appended_bit;
    logic                              m_last_result;

    crc_tracker tracker = new();
    bit         quiet = 1'b0;
    int         hold_left = 0;
    int         cycles = 0;
    int         random_items = 0;

    bit_serial_crc_generator #(.MAX_CRC_WIDTH(MAX_W)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_bit       (s_data_bit),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_crc_value      (m_crc_value),
        .m_appended_bit   (m_appended_bit),
        .m_last_result    (m_last_result)
    );

    always #10 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_word(m_result_kind, m_crc_value, m_appended_bit, m_last_result);
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready   <= 1'b1;
            hold_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // call it just after the clock rises; it returns once the DUT has accepted the word
    task automatic send_bit(input logic d, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_data_bit       <= d;
        s_end_of_message <= e;
        do @(posedge aclk); while (!s_ready);
        tracker.take_bit(d, e);
    endtask

    task automatic send_message(input int len, input bit close);
        int b;
        for (b = 0; b < len; b++)
            send_bit(1'($urandom_range(0, 1)), close && (b == len - 1));
    endtask

    task automatic hold_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.expected_words.size() != 0);
    endtask

    // drain everything, including bits still in flight that produce no word
    task automatic end_phase();
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [3:0] sel,
                                input logic [bscrc_pkg::CFG_DATA_W-1:0] w,
                                input logic [bscrc_pkg::CFG_DATA_W-1:0] p,
                                input logic [bscrc_pkg::CFG_DATA_W-1:0] iv,
                                input logic [bscrc_pkg::CFG_DATA_W-1:0] ap);
        logic [bscrc_pkg::CFG_DATA_W-1:0] vals [4];
        int i;
        vals[bscrc_pkg::CFG_CRC_WIDTH]     = w;
        vals[bscrc_pkg::CFG_POLYNOMIAL]    = p;
        vals[bscrc_pkg::CFG_INIT_VALUE]    = iv;
        vals[bscrc_pkg::CFG_APPEND_ENABLE] = ap;
        for (i = 0; i < 4; i++) begin
            if (sel[i]) begin
                cfg_we    <= 1'b1;
                cfg_index <= bscrc_pkg::cfg_index_t'(i);
                cfg_wdata <= vals[i];
                @(posedge aclk);
                tracker.write_reg(bscrc_pkg::cfg_index_t'(i), vals[i]);
            end
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [bscrc_pkg::WIDTH_W-1:0] w6;
        logic [3:0]                    sel;
        int                            n_msgs;
        int                            len;
        int                            m;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // default settings after reset
        send_bit(1'b1, 1'b1);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        end_phase();

        // widest CRC with appending, then leave a message open
        program_regs(ALL_REGS, 33'd32, 33'h1_04C1_1DB7, 33'h0_FFFF_FFFF, 33'd1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        end_phase();

        // settings change in the middle of a message; odd width rounds down
        program_regs((4'b1 << bscrc_pkg::CFG_CRC_WIDTH) | (4'b1 << bscrc_pkg::CFG_POLYNOMIAL),
                     33'd5, 33'h13, 33'd0, 33'd0);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b1);
        end_phase();

        // width above range saturates, all-ones polynomial
        program_regs(ALL_REGS, 33'd63, 33'h1_FFFF_FFFF, 33'd0, 33'd0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        end_phase();

        // width below range saturates to the minimum
        program_regs(ALL_REGS, 33'd0, 33'h13, 33'h0_FFFF_FFFF, 33'd1);
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b1);
        end_phase();

        // odd width above range, zero polynomial
        program_regs(ALL_REGS, 33'd33, 33'd0, 33'h0_A5A5_A5A5, 33'd1);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
        end_phase();

        while (random_items < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       w6 = bscrc_pkg::MIN_CRC_WIDTH;
                1:       w6 = 6'd32;
                2:       w6 = 6'($urandom_range(0, 63));
                default: w6 = 6'($urandom_range(4, 32));
            endcase
            sel = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : ALL_REGS;
            program_regs(sel, {27'($urandom()), w6}, {1'($urandom()), 32'($urandom())},
                         {1'($urandom()), 32'($urandom())}, {32'($urandom()), 1'($urandom())});
            n_msgs = $urandom_range(1, 6);
            for (m = 0; m < n_msgs; m++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                send_message(len, 1'b1);
                random_items += len;
                if ($urandom_range(0, 19) == 0) hold_for_results();
            end
            // sometimes the next settings land inside an open message
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 5);
                send_message(len, 1'b0);
                random_items += len;
            end
            end_phase();
        end

        quiet = 1'b0;
        if (tracker.errors == 0 && tracker.expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
